### design/cfrd_pkg.sv
// Shared constants, types and helper functions for the command frame receiver.
package cfrd_pkg;

   localparam int BUFFER_BYTES_DEFAULT  = 32;
   localparam int SERVICE_SLOTS_DEFAULT = 4;

   // Number of service flag registers on the configuration port.
   localparam int FLAG_REGS = 4;

   // Completed frames waiting for replay; each one owns one bank of the payload RAM.
   localparam int QUEUE_DEPTH = 2;
   localparam int BANK_W      = $clog2(QUEUE_DEPTH);

   localparam int SVC_W       = 2;
   localparam int CSR_INDEX_W = 3;

   localparam logic [7:0] TERM_CR          = 8'h0d;
   localparam logic [7:0] TERM_LF          = 8'h0a;
   localparam logic [7:0] START_BYTE_RESET = 8'h24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_BYTE    = 3'd0,
      REG_SERVICE_COUNT = 3'd1,
      REG_FLAG_0        = 3'd2,
      REG_FLAG_1        = 3'd3,
      REG_FLAG_2        = 3'd4,
      REG_FLAG_3        = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [BANK_W-1:0] wr_bank;
   } queue_status_type;

   // Flag registers actually built for a given slot count.
   function automatic int slot_used(input int service_slots);
      return (service_slots < FLAG_REGS) ? service_slots : FLAG_REGS;
   endfunction

   // Width of one frame descriptor: command, service, length, overflow, bank.
   function automatic int desc_bits(input int buffer_bytes);
      return 8 + SVC_W + $clog2(buffer_bytes + 1) + 1 + BANK_W;
   endfunction

endpackage

### design/cfrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/cfrd_queue.sv
// Short descriptor queue between the frame parser and the replay engine.
module cfrd_queue #(
   parameter int WIDTH = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           head_data,
   output cfrd_pkg::queue_status_type status
);
   import cfrd_pkg::*;

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [BANK_W-1:0] wr_ptr_ff;
   logic [BANK_W-1:0] wr_ptr_in;
   logic [BANK_W-1:0] rd_ptr_ff;
   logic [BANK_W-1:0] rd_ptr_in;
   logic [BANK_W:0]   count_ff;
   logic [BANK_W:0]   count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + BANK_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + BANK_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (BANK_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (BANK_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data      = entry_ff[rd_ptr_ff];
   assign status.full    = (count_ff == (BANK_W+1)'(QUEUE_DEPTH));
   assign status.empty   = (count_ff == '0);
   assign status.wr_bank = wr_ptr_ff;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("descriptor pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("descriptor popped from an empty queue");

endmodule

### design/cfrd_front.sv
// Frame parser: finds the start byte, holds the command, stores the payload, matches services.
module cfrd_front #(
   parameter int BUFFER_BYTES  = 32,
   parameter int SERVICE_SLOTS = 4
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic [7:0]                                    req_rx_byte,
   input  logic [7:0]                                    start_byte,
   input  logic [2:0]                                    service_count,
   input  logic [cfrd_pkg::slot_used(SERVICE_SLOTS)-1:0][7:0] flags,
   input  cfrd_pkg::queue_status_type                    qstat,
   output logic                                          push,
   output logic [cfrd_pkg::desc_bits(BUFFER_BYTES)-1:0]  push_data,
   output logic                                          ram_wr_en,
   output logic [cfrd_pkg::BANK_W+$clog2(BUFFER_BYTES)-1:0] ram_wr_addr,
   output logic [7:0]                                    ram_wr_data
);
   import cfrd_pkg::*;

   localparam int AW        = $clog2(BUFFER_BYTES);
   localparam int CNT_W     = $clog2(BUFFER_BYTES + 1);
   localparam int SLOT_USED = slot_used(SERVICE_SLOTS);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CMD,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic [7:0]       command;
      logic [SVC_W-1:0] svc;
      logic [CNT_W-1:0] length;
      logic             ovf;
      logic [BANK_W-1:0] bank;
   } desc_type;

   phase_type        phase_ff;
   phase_type        phase_in;
   logic [7:0]       cmd_ff;
   logic [7:0]       cmd_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             ovf_ff;
   logic             ovf_in;
   logic             accept;
   logic             is_term;
   logic             room;
   logic             hit;
   logic [SVC_W-1:0] hit_idx;
   desc_type         desc;

   // First registered flag that equals the held command wins.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int k = SLOT_USED - 1; k >= 0; k--) begin
         if ((3'(k) < service_count) && (flags[k] == cmd_ff)) begin
            hit     = 1'b1;
            hit_idx = SVC_W'(k);
         end
      end
   end

   always_comb begin
      accept    = req_valid && !qstat.full;
      is_term   = (req_rx_byte == TERM_CR) || (req_rx_byte == TERM_LF);
      room      = (count_ff < CNT_W'(BUFFER_BYTES));
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      ram_wr_en = 1'b0;
      push      = 1'b0;
      if (accept) begin
         if ((phase_ff != PH_DATA) && (req_rx_byte == start_byte)) begin
            phase_in = PH_CMD;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            case (phase_ff)
               PH_CMD: begin
                  cmd_in   = req_rx_byte;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  if (room) begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (is_term) begin
                     phase_in = PH_IDLE;
                     push     = hit;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      desc.command = cmd_ff;
      desc.svc     = hit_idx;
      desc.length  = count_in;
      desc.ovf     = ovf_in;
      desc.bank    = qstat.wr_bank;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign req_stall   = qstat.full;
   assign push_data   = desc;
   assign ram_wr_addr = {qstat.wr_bank, count_ff[AW-1:0]};
   assign ram_wr_data = req_rx_byte;

endmodule

### design/cfrd_back.sv
// Replay engine: reads a stored frame out of the payload RAM one word per cycle unless rsp_stall holds it.
module cfrd_back #(
   parameter int BUFFER_BYTES = 32
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic [cfrd_pkg::desc_bits(BUFFER_BYTES)-1:0] head_data,
   input  cfrd_pkg::queue_status_type                   qstat,
   output logic                                         pop,
   output logic                                         ram_rd_en,
   output logic [cfrd_pkg::BANK_W+$clog2(BUFFER_BYTES)-1:0] ram_rd_addr,
   input  logic [7:0]                                   ram_rd_data,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic [7:0]                                   rsp_command,
   output logic [1:0]                                   rsp_service_index,
   output logic [7:0]                                   rsp_data_byte,
   output logic [4:0]                                   rsp_byte_position,
   output logic [5:0]                                   rsp_payload_length,
   output logic                                         rsp_overflowed,
   output logic                                         rsp_last
);
   import cfrd_pkg::*;

   localparam int AW    = $clog2(BUFFER_BYTES);
   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [7:0]       command;
      logic [SVC_W-1:0] svc;
      logic [CNT_W-1:0] length;
      logic             ovf;
      logic [BANK_W-1:0] bank;
   } desc_type;

   state_type     state_ff;
   state_type     state_in;
   logic [AW-1:0] pos_ff;
   logic [AW-1:0] pos_in;
   logic          last;
   desc_type      head;

   assign head = head_data;
   assign last = ((CNT_W'(pos_ff) + CNT_W'(1)) == head.length);

   // The RAM read register holds its word while the receiver stalls.
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      ram_rd_en = 1'b0;
      pop       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               ram_rd_en = 1'b1;
               pos_in    = '0;
               state_in  = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (last) begin
                  pop      = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  ram_rd_en = 1'b1;
                  pos_in    = pos_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   assign ram_rd_addr        = {head.bank, pos_in};
   assign rsp_valid          = (state_ff == ST_SEND);
   assign rsp_command        = head.command;
   assign rsp_service_index  = head.svc;
   assign rsp_data_byte      = ram_rd_data;
   assign rsp_byte_position  = 5'(pos_ff);
   assign rsp_payload_length = 6'(head.length);
   assign rsp_overflowed     = head.ovf;
   assign rsp_last           = last;

   a_valid_has_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !qstat.empty)
      else $error("result word shown with no frame in the queue");

   a_position_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> (rsp_valid && (pos_ff == $past(pos_ff) + AW'(1))))
      else $error("replay position did not advance by one");

endmodule

### design/command_frame_receiver_dispatch.sv
// Top level of the start-byte command frame receiver with service dispatch.
//
// Received bytes enter on the req_ channel, one word per accepted handshake.
// Bytes are ignored until the start byte; the next byte is the command and
// every later byte, up to and including a CR or LF terminator, is stored
// while the buffer has room, later ones setting the overflow flag. On the
// terminator the command is matched against the service flags; a match
// queues the frame for replay, and the rsp_ channel then delivers one word
// per stored byte, tagged with the service index, last word flagged. A frame
// with no match produces no words at all. The parser takes one byte per
// cycle while req_stall is low; replay gives one word per cycle while
// rsp_stall is low, limited by the single read port of the payload RAM,
// with an idle state between frames. With the replay engine free, a frame's
// first word shows once its descriptor is queued and the RAM read registered.
// Two completed frames can wait for replay, each in its own RAM bank; req_stall
// rises only while both banks are held, so a stalled receiver only stops the
// input once a second matching frame has finished.
// The csr_ port is always ready; write it only while the block is idle.
// Reset restores the register defaults and empties the queue; the payload RAM
// is not cleared, and no clearing pass is needed.
module command_frame_receiver_dispatch #(
   parameter int BUFFER_BYTES  = cfrd_pkg::BUFFER_BYTES_DEFAULT,
   parameter int SERVICE_SLOTS = cfrd_pkg::SERVICE_SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_command,
   output logic [1:0]                       rsp_service_index,
   output logic [7:0]                       rsp_data_byte,
   output logic [4:0]                       rsp_byte_position,
   output logic [5:0]                       rsp_payload_length,
   output logic                             rsp_overflowed,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfrd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_data
);
   import cfrd_pkg::*;

   localparam int AW        = $clog2(BUFFER_BYTES);
   localparam int ADDR_W    = BANK_W + AW;
   localparam int RAM_DEPTH = QUEUE_DEPTH << AW;
   localparam int DESC_W    = desc_bits(BUFFER_BYTES);
   localparam int SLOT_USED = slot_used(SERVICE_SLOTS);

   logic [7:0]                 start_byte_ff;
   logic [2:0]                 service_count_ff;
   logic [SLOT_USED-1:0][7:0]  flags_ff;

   queue_status_type           qstat;
   logic                       push;
   logic [DESC_W-1:0]          push_data;
   logic                       pop;
   logic [DESC_W-1:0]          head_data;
   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   logic [7:0]                 ram_wr_data;
   logic                       ram_rd_en;
   logic [ADDR_W-1:0]          ram_rd_addr;
   logic [7:0]                 ram_rd_data;

   // Configuration registers. Flag writes beyond the built slots are dropped,
   // since those slots can never take part in a match.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff    <= START_BYTE_RESET;
         service_count_ff <= '0;
         flags_ff         <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START_BYTE: begin
               start_byte_ff <= csr_data;
            end
            REG_SERVICE_COUNT: begin
               service_count_ff <= csr_data[2:0];
            end
            default: begin
               for (int k = 0; k < SLOT_USED; k++) begin
                  if (csr_index == (CSR_INDEX_W'(REG_FLAG_0) + CSR_INDEX_W'(k))) begin
                     flags_ff[k] <= csr_data;
                  end
               end
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   cfrd_front #(
      .BUFFER_BYTES  (BUFFER_BYTES),
      .SERVICE_SLOTS (SERVICE_SLOTS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .start_byte    (start_byte_ff),
      .service_count (service_count_ff),
      .flags         (flags_ff),
      .qstat         (qstat),
      .push          (push),
      .push_data     (push_data),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data)
   );

   cfrd_queue #(
      .WIDTH (DESC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (qstat)
   );

   cfrd_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cfrd_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_data          (head_data),
      .qstat              (qstat),
      .pop                (pop),
      .ram_rd_en          (ram_rd_en),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_command        (rsp_command),
      .rsp_service_index  (rsp_service_index),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_payload_length (rsp_payload_length),
      .rsp_overflowed     (rsp_overflowed),
      .rsp_last           (rsp_last)
   );

endmodule
